// ===== design/des_pkg.sv =====
// ----------------------------------------------------------------------------
// DES package
// Shared constants, types, permutation tables and S-box lookup for the DES
// block cipher.
// ----------------------------------------------------------------------------
package des_pkg;

    localparam int BLOCK_W      = 64;
    localparam int HALF_W       = 32;
    localparam int CD_W         = 28;
    localparam int SUBKEY_W     = 48;
    localparam int MAX_ROUNDS   = 16;
    localparam int ROUND_COUNT_DEF = 16;
    localparam int ROUND_IDX_W  = 4;

    localparam logic REQ_ENCRYPT = 1'b0;
    localparam logic REQ_DECRYPT = 1'b1;

    typedef logic [ROUND_IDX_W-1:0] round_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND,
        ST_HOLD
    } ctrl_state_t;

    // controller to datapath
    typedef struct packed {
        logic       load;     // latch block after IP
        logic       round;    // perform one Feistel round
        logic       finish;   // produce result into output register
        round_idx_t key_idx;  // subkey used by this round
    } dp_cmd_t;

    // Output bit i takes input bit tab[i]-1.
    localparam byte TAB_IP [64] = '{
        58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
        62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
        57,49,41,33,25,17,9,1,  59,51,43,35,27,19,11,3,
        61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7 };

    localparam byte TAB_IPINV [64] = '{
        40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
        38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
        36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
        34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25 };

    localparam byte TAB_E [48] = '{
        32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
        16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29,
        28,29,30,31,32,1 };

    localparam byte TAB_P [32] = '{
        16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
        2,8,24,14,32,27,3,9,    19,13,30,6,22,11,4,25 };

    localparam byte TAB_PC1 [56] = '{
        57,49,41,33,25,17,9, 1,58,50,42,34,26,18,
        10,2,59,51,43,35,27, 19,11,3,60,52,44,36,
        63,55,47,39,31,23,15, 7,62,54,46,38,30,22,
        14,6,61,53,45,37,29, 21,13,5,28,20,12,4 };

    localparam byte TAB_PC2 [48] = '{
        14,17,11,24,1,5, 3,28,15,6,21,10, 23,19,12,4,26,8,
        16,7,27,20,13,2, 41,52,31,37,47,55, 30,40,51,45,33,48,
        44,49,39,56,34,53, 46,42,50,36,29,32 };

    localparam byte TAB_SHIFT [16] = '{1,1,2,2,2,2,2,2,1,2,2,2,2,2,2,1};

    localparam byte TAB_SBOX [8][64] = '{
        '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7, 0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
          4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0, 15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
        '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10, 3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
          0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15, 13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
        '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8, 13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
          13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7, 1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
        '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15, 13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
          10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4, 3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
        '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9, 14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
          4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14, 11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
        '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11, 10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
          9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6, 4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
        '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1, 13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
          1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2, 6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
        '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7, 1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
          7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8, 2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11} };

    function automatic logic [BLOCK_W-1:0] perm_ip(input logic [BLOCK_W-1:0] v);
        logic [BLOCK_W-1:0] r;
        for (int i = 0; i < 64; i++) r[i] = v[TAB_IP[i]-1];
        return r;
    endfunction

    function automatic logic [BLOCK_W-1:0] perm_ipinv(input logic [BLOCK_W-1:0] v);
        logic [BLOCK_W-1:0] r;
        for (int i = 0; i < 64; i++) r[i] = v[TAB_IPINV[i]-1];
        return r;
    endfunction

    function automatic logic [2*CD_W-1:0] perm_pc1(input logic [BLOCK_W-1:0] v);
        logic [2*CD_W-1:0] r;
        for (int i = 0; i < 56; i++) r[i] = v[TAB_PC1[i]-1];
        return r;
    endfunction

    function automatic logic [SUBKEY_W-1:0] perm_pc2(input logic [2*CD_W-1:0] v);
        logic [SUBKEY_W-1:0] r;
        for (int i = 0; i < 48; i++) r[i] = v[TAB_PC2[i]-1];
        return r;
    endfunction

    // Left rotation in DES order: new bit j = old bit (j+s) mod 28.
    function automatic logic [CD_W-1:0] rot28(input logic [CD_W-1:0] h,
                                              input logic two);
        return two ? {h[1:0], h[CD_W-1:2]} : {h[0], h[CD_W-1:1]};
    endfunction

    function automatic logic [HALF_W-1:0] feistel(input logic [HALF_W-1:0] r,
                                                  input logic [SUBKEY_W-1:0] sk);
        logic [SUBKEY_W-1:0] x;
        logic [HALF_W-1:0]   s;
        logic [HALF_W-1:0]   p;
        logic [5:0]          b;
        logic [3:0]          v;
        for (int i = 0; i < 48; i++) x[i] = r[TAB_E[i]-1];
        x = x ^ sk;
        for (int g = 0; g < 8; g++) begin
            b = x[6*g +: 6];
            v = 4'(TAB_SBOX[g][{b[0], b[5], b[1], b[2], b[3], b[4]}]);
            for (int j = 0; j < 4; j++) s[4*g + j] = v[3-j];
        end
        for (int i = 0; i < 32; i++) p[i] = s[TAB_P[i]-1];
        return p;
    endfunction

endpackage

// ===== design/des_keysched.sv =====
// ----------------------------------------------------------------------------
// DES key schedule
// Computes all sixteen subkeys from the key register after each key write.
// ----------------------------------------------------------------------------
module des_keysched (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          key_we,
    input  logic [des_pkg::BLOCK_W-1:0]   key_data,
    input  des_pkg::round_idx_t           key_idx,
    output logic [des_pkg::SUBKEY_W-1:0]  subkey
);
    import des_pkg::*;

    logic [BLOCK_W-1:0] key_reg;
    logic [BLOCK_W-1:0] key_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg <= '0;
        end else begin
            key_reg <= key_next;
        end
    end

    assign key_next = key_we ? key_data : key_reg;

    // The rotation chain is fixed wiring from the stored key.
    logic [2*CD_W-1:0] cd0;
    logic [CD_W-1:0]   c_r [MAX_ROUNDS];
    logic [CD_W-1:0]   d_r [MAX_ROUNDS];
    logic [SUBKEY_W-1:0] sk_r [MAX_ROUNDS];

    assign cd0 = perm_pc1(key_reg);

    always_comb begin
        for (int i = 0; i < MAX_ROUNDS; i++) begin
            if (i == 0) begin
                c_r[i] = rot28(cd0[CD_W-1:0], TAB_SHIFT[i] == 2);
                d_r[i] = rot28(cd0[2*CD_W-1:CD_W], TAB_SHIFT[i] == 2);
            end else begin
                c_r[i] = rot28(c_r[i-1], TAB_SHIFT[i] == 2);
                d_r[i] = rot28(d_r[i-1], TAB_SHIFT[i] == 2);
            end
            sk_r[i] = perm_pc2({d_r[i], c_r[i]});
        end
    end

    assign subkey = sk_r[key_idx];

endmodule

// ===== design/des_datapath.sv =====
// ----------------------------------------------------------------------------
// DES datapath
// Holds the L/R halves, runs one Feistel round per cycle and keeps the
// output register.
// ----------------------------------------------------------------------------
module des_datapath (
    input  logic                          aclk,
    input  des_pkg::dp_cmd_t              cmd,
    input  logic [des_pkg::BLOCK_W-1:0]   in_block,
    input  logic [des_pkg::SUBKEY_W-1:0]  subkey,
    output logic [des_pkg::BLOCK_W-1:0]   out_block
);
    import des_pkg::*;

    logic [HALF_W-1:0]  l_reg, l_next, r_reg, r_next;
    logic [BLOCK_W-1:0] out_reg, out_next;
    logic [BLOCK_W-1:0] ip_val;

    assign ip_val = perm_ip(in_block);

    always_comb begin
        l_next   = l_reg;
        r_next   = r_reg;
        out_next = out_reg;
        if (cmd.load) begin
            l_next = ip_val[HALF_W-1:0];
            r_next = ip_val[BLOCK_W-1:HALF_W];
        end else if (cmd.round) begin
            l_next = r_reg;
            r_next = l_reg ^ feistel(r_reg, subkey);
        end
        if (cmd.finish) begin
            out_next = perm_ipinv({l_reg, r_reg});
        end
    end

    always_ff @(posedge aclk) begin
        l_reg   <= l_next;
        r_reg   <= r_next;
        out_reg <= out_next;
    end

    assign out_block = out_reg;

endmodule

// ===== design/des_ctrl.sv =====
// ----------------------------------------------------------------------------
// DES controller
// Sequences load, rounds and result handoff.
// ----------------------------------------------------------------------------
module des_ctrl #(
    parameter int ROUND_COUNT = des_pkg::ROUND_COUNT_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_req_type,
    output logic                 m_valid,
    input  logic                 m_ready,
    output des_pkg::dp_cmd_t     cmd
);
    import des_pkg::*;

    localparam round_idx_t LAST = round_idx_t'(ROUND_COUNT - 1);

    ctrl_state_t state_reg, state_next;
    round_idx_t  cnt_reg, cnt_next;
    logic        dec_reg, dec_next;
    logic        mv_reg, mv_next;
    logic        s_xfer;

    assign s_xfer = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            dec_reg   <= 1'b0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            dec_reg   <= dec_next;
            mv_reg    <= mv_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        dec_next   = dec_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    state_next = ST_ROUND;
                    cnt_next   = '0;
                    dec_next   = (s_req_type == REQ_DECRYPT);
                end
            end
            ST_ROUND: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST) state_next = ST_HOLD;
            end
            ST_HOLD: begin
                // wait for the output register to be free
                if (!mv_reg || m_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready     = 1'b0;
        cmd.load    = 1'b0;
        cmd.round   = 1'b0;
        cmd.finish  = 1'b0;
        cmd.key_idx = dec_reg ? round_idx_t'(LAST - cnt_reg) : cnt_reg;
        mv_next     = mv_reg && !m_ready;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = 1'b1;
            end
            ST_ROUND: cmd.round = 1'b1;
            ST_HOLD: begin
                if (!mv_reg || m_ready) begin
                    cmd.finish = 1'b1;
                    mv_next    = 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign m_valid = mv_reg;

    a_round_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ROUND && cnt_reg == LAST) |=> state_reg == ST_HOLD)
        else $error("round count overrun");
    a_finish_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |=> mv_reg)
        else $error("finish did not raise valid");
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> (!mv_reg || m_ready))
        else $error("result overwritten");
    a_accept_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer |-> state_reg == ST_IDLE)
        else $error("accept while busy");

endmodule

// ===== design/des_block_cipher.sv =====
// ----------------------------------------------------------------------------
// DES block cipher
// Single-block DES engine, ECB, one Feistel round per clock.
//
//   channel  direction  signals
//   input    in         s_valid s_ready s_req_type s_data_block
//   result   out        m_valid m_ready m_result_block
//   key      in         cfg_we cfg_wdata
//
// An item is loaded with IP, then runs its rounds on the single shared round
// unit, then is written to the output register.
// The next item is accepted while the previous result waits in m_ outputs.
// Reset (aresetn, synchronous) clears control and loads the all-zero key.
// A stalled result holds the engine only in its final state, ST_HOLD.
// ----------------------------------------------------------------------------
module des_block_cipher #(
    parameter int ROUND_COUNT = des_pkg::ROUND_COUNT_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [des_pkg::BLOCK_W-1:0] cfg_wdata,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_req_type,
    input  logic [des_pkg::BLOCK_W-1:0] s_data_block,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [des_pkg::BLOCK_W-1:0] m_result_block
);
    import des_pkg::*;

    dp_cmd_t             cmd;
    logic [SUBKEY_W-1:0] subkey;

    des_ctrl #(.ROUND_COUNT(ROUND_COUNT)) u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_req_type(s_req_type),
        .m_valid(m_valid), .m_ready(m_ready), .cmd(cmd));

    des_keysched u_keys (
        .aclk(aclk), .aresetn(aresetn),
        .key_we(cfg_we), .key_data(cfg_wdata),
        .key_idx(cmd.key_idx), .subkey(subkey));

    des_datapath u_dp (
        .aclk(aclk), .cmd(cmd), .in_block(s_data_block),
        .subkey(subkey), .out_block(m_result_block));

endmodule
